// ===== design/bfdc_pkg.sv =====
// Shared types, constants and helper functions for the filtered B-dot dipole controller.
// Depends on nothing; every other file of the block imports it.
package bfdc_pkg;

    // Axis count and field widths.
    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;
    localparam int FIELD_W  = 16;
    localparam int DIFF_W   = FIELD_W + 1;
    localparam int RATE_W   = 24;
    localparam int GAIN_W   = 24;
    localparam int DECAY_W  = 16;
    localparam int Q_SHIFT  = 16;

    // Multiplier operands are 25-bit signed; the product is kept at 50 bits.
    localparam int OPND_W   = 25;
    localparam int PROD_W   = 2 * OPND_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z       = 3'd4;

    // Operand selection for the shared multiplier.
    localparam logic [1:0] MUL_SEL_DIFF  = 2'd0;
    localparam logic [1:0] MUL_SEL_DECAY = 2'd1;
    localparam logic [1:0] MUL_SEL_GAIN  = 2'd2;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_in;
        logic              mul_en;
        logic [1:0]        mul_sel;
        logic              acc_en;
        logic              rate_en;
        logic              dip_en;
        logic              load_out;
        logic [AXIS_W-1:0] axis;
    } bfdc_cmd_t;

    // Round a Q.16 value half up to an integer and saturate it to 24-bit signed.
    function automatic logic signed [RATE_W-1:0] round_sat(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        logic signed [PROD_W-1:0] s;
        logic signed [PROD_W-1:0] max_v;
        logic signed [PROD_W-1:0] min_v;
        t = v + PROD_W'(1 << (Q_SHIFT - 1));
        s = t >>> Q_SHIFT;
        max_v = PROD_W'((1 << (RATE_W - 1)) - 1);
        min_v = -PROD_W'(1 << (RATE_W - 1));
        if (s > max_v)
        begin
            round_sat = max_v[RATE_W-1:0];
        end
        else if (s < min_v)
        begin
            round_sat = min_v[RATE_W-1:0];
        end
        else
        begin
            round_sat = s[RATE_W-1:0];
        end
    endfunction

endpackage

// ===== design/bfdc_datapath.sv =====
// Datapath of the filtered B-dot controller: configuration registers, filter state,
// one shared 25x25 multiplier, rounding and saturation, and the result register.
// Depends on bfdc_pkg.
module bfdc_datapath (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  bfdc_pkg::bfdc_cmd_t                        cmd,
    input  logic                                       cfg_write_en,
    input  logic [bfdc_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [bfdc_pkg::CFG_DATA_W-1:0]            cfg_data,
    input  logic signed [bfdc_pkg::FIELD_W-1:0]        field_x,
    input  logic signed [bfdc_pkg::FIELD_W-1:0]        field_y,
    input  logic signed [bfdc_pkg::FIELD_W-1:0]        field_z,
    output logic signed [bfdc_pkg::RATE_W-1:0]         dipole_x,
    output logic signed [bfdc_pkg::RATE_W-1:0]         dipole_y,
    output logic signed [bfdc_pkg::RATE_W-1:0]         dipole_z
);
    import bfdc_pkg::*;

    // Configuration registers.
    logic [GAIN_W-1:0]  filter_gain_reg;
    logic [DECAY_W-1:0] decay_factor_reg;
    logic [GAIN_W-1:0]  gain_reg [AXES];

    // Filter state carried from item to item.
    logic signed [FIELD_W-1:0] prev_field_reg [AXES];
    logic signed [RATE_W-1:0]  prev_rate_reg  [AXES];

    // Working registers of the current item.
    logic signed [FIELD_W-1:0] field_reg [AXES];
    logic signed [PROD_W-1:0]  product_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic signed [RATE_W-1:0]  rate_reg;
    logic signed [RATE_W-1:0]  dip_reg [AXES];
    logic signed [RATE_W-1:0]  out_x_reg;
    logic signed [RATE_W-1:0]  out_y_reg;
    logic signed [RATE_W-1:0]  out_z_reg;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [OPND_W-1:0]  opnd_a;
    logic signed [OPND_W-1:0]  opnd_b;
    logic signed [PROD_W-1:0]  product_next;
    logic signed [RATE_W-1:0]  rate_next;
    logic signed [RATE_W-1:0]  dip_next;

    // Configuration writes; indexes past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_gain_reg  <= '0;
            decay_factor_reg <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                gain_reg[i] <= '0;
            end
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_FILTER_GAIN:  filter_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_DECAY_FACTOR: decay_factor_reg <= cfg_data[DECAY_W-1:0];
                REG_GAIN_X:       gain_reg[0]      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_Y:       gain_reg[1]      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_Z:       gain_reg[2]      <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Field difference of the selected axis, exact in 17 bits.
    assign diff = DIFF_W'(field_reg[cmd.axis]) - DIFF_W'(prev_field_reg[cmd.axis]);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SEL_DIFF:
            begin
                opnd_a = OPND_W'({1'b0, filter_gain_reg});
                opnd_b = OPND_W'(diff);
            end
            MUL_SEL_DECAY:
            begin
                opnd_a = OPND_W'({1'b0, decay_factor_reg});
                opnd_b = OPND_W'(prev_rate_reg[cmd.axis]);
            end
            MUL_SEL_GAIN:
            begin
                opnd_a = OPND_W'({1'b0, gain_reg[cmd.axis]});
                opnd_b = OPND_W'(rate_reg);
            end
            default:
            begin
                opnd_a = '0;
                opnd_b = '0;
            end
        endcase
    end

    assign product_next = opnd_a * opnd_b;

    // Rate from the two filter terms, and dipole from the negated gain product.
    assign rate_next = round_sat(acc_reg + product_reg);
    assign dip_next  = round_sat(-product_reg);

    // Filter state updates once the rate of an axis is known.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                prev_field_reg[i] <= '0;
                prev_rate_reg[i]  <= '0;
            end
        end
        else if (cmd.rate_en)
        begin
            prev_field_reg[cmd.axis] <= field_reg[cmd.axis];
            prev_rate_reg[cmd.axis]  <= rate_next;
        end
    end

    // Working registers; payload only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            field_reg[0] <= field_x;
            field_reg[1] <= field_y;
            field_reg[2] <= field_z;
        end
        if (cmd.mul_en)
        begin
            product_reg <= product_next;
        end
        if (cmd.acc_en)
        begin
            acc_reg <= product_reg;
        end
        if (cmd.rate_en)
        begin
            rate_reg <= rate_next;
        end
        if (cmd.dip_en)
        begin
            dip_reg[cmd.axis] <= dip_next;
        end
        if (cmd.load_out)
        begin
            out_x_reg <= dip_reg[0];
            out_y_reg <= dip_reg[1];
            out_z_reg <= dip_reg[2];
        end
    end

    assign dipole_x = out_x_reg;
    assign dipole_y = out_y_reg;
    assign dipole_z = out_z_reg;

endmodule

// ===== design/bfdc_controller.sv =====
// Controller state machine of the filtered B-dot controller: sequences the three
// multiplies of each axis and owns both handshakes. Depends on bfdc_pkg.
module bfdc_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output bfdc_pkg::bfdc_cmd_t cmd
);
    import bfdc_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MUL_DIFF  = 3'd1;
    localparam logic [2:0] ST_MUL_DECAY = 3'd2;
    localparam logic [2:0] ST_RATE      = 3'd3;
    localparam logic [2:0] ST_MUL_GAIN  = 3'd4;
    localparam logic [2:0] ST_DIP       = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [AXIS_W-1:0] axis_reg;
    logic [AXIS_W-1:0] axis_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.axis       = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    axis_next   = '0;
                    state_next  = ST_MUL_DIFF;
                end
            end
            ST_MUL_DIFF:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEL_DIFF;
                state_next  = ST_MUL_DECAY;
            end
            ST_MUL_DECAY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEL_DECAY;
                cmd.acc_en  = 1'b1;
                state_next  = ST_RATE;
            end
            ST_RATE:
            begin
                cmd.rate_en = 1'b1;
                state_next  = ST_MUL_GAIN;
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEL_GAIN;
                state_next  = ST_DIP;
            end
            ST_DIP:
            begin
                cmd.dip_en = 1'b1;
                if (axis_reg == LAST_AXIS)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_MUL_DIFF;
                end
            end
            ST_DONE:
            begin
                // Move the result into the output register once it is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/bdot_filtered_dipole_control.sv =====
// Top level of the filtered B-dot dipole controller: joins the controller and datapath.
// Depends on bfdc_pkg, bfdc_controller and bfdc_datapath.
//
//   channel   handshake              payload
//   -------   --------------------   ----------------------------------
//   input     in_valid / in_ready    field_x, field_y, field_z
//   output    out_valid / out_ready  dipole_x, dipole_y, dipole_z
//   config    cfg_write_en           cfg_index, cfg_data
//
// After the edge that accepts an item, the controller runs five steps per axis (two filter
// multiplies, rate rounding, gain multiply, dipole rounding) on one shared 25x25
// multiplier, then a hand-over state that loads the output register. Items do not
// overlap: the next one is taken only in the idle state, after the hand-over.
// A new item is accepted as soon as the previous one sits in the output register,
// even while that result still waits for out_ready; if the register is still full at
// the end of an item, the block holds there until it is taken.
// Reset clears the configuration registers, the filter state and all control state.
module bdot_filtered_dipole_control (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [bfdc_pkg::FIELD_W-1:0]    field_x,
    input  logic signed [bfdc_pkg::FIELD_W-1:0]    field_y,
    input  logic signed [bfdc_pkg::FIELD_W-1:0]    field_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [bfdc_pkg::RATE_W-1:0]     dipole_x,
    output logic signed [bfdc_pkg::RATE_W-1:0]     dipole_y,
    output logic signed [bfdc_pkg::RATE_W-1:0]     dipole_z,
    input  logic                                   cfg_write_en,
    input  logic [bfdc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bfdc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import bfdc_pkg::*;

    bfdc_cmd_t cmd;

    // Sequencer and handshakes.
    bfdc_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Arithmetic, state and registers.
    bfdc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .field_x      (field_x),
        .field_y      (field_y),
        .field_z      (field_z),
        .dipole_x     (dipole_x),
        .dipole_y     (dipole_y),
        .dipole_z     (dipole_z)
    );

endmodule

// ===== tb/tb_bdot_filtered_dipole_control.sv =====
// Self-checking testbench for the filtered B-dot dipole controller: a directed part,
// then randomized magnetometer sequences under changing gains and handshake idling.
// Depends on bfdc_pkg and bdot_filtered_dipole_control.
module tb_bdot_filtered_dipole_control;

    import bfdc_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  FIELD_MAX   = (1 << (FIELD_W - 1)) - 1;
    localparam int  FIELD_MIN   = -(1 << (FIELD_W - 1));
    localparam longint RATE_MAX = (64'sd1 <<< (RATE_W - 1)) - 1;
    localparam longint RATE_MIN = -(64'sd1 <<< (RATE_W - 1));
    localparam int  RANDOM_PHASES    = 8;
    localparam int  ITEMS_PER_PHASE  = 180;

    // Axis 0 is x, 1 is y, 2 is z.
    typedef logic [AXES-1:0][FIELD_W-1:0] mag_sample_t;
    typedef logic [AXES-1:0][RATE_W-1:0]  dipole_cmd_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic signed [FIELD_W-1:0]    field_x = '0;
    logic signed [FIELD_W-1:0]    field_y = '0;
    logic signed [FIELD_W-1:0]    field_z = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [RATE_W-1:0]     dipole_x;
    logic signed [RATE_W-1:0]     dipole_y;
    logic signed [RATE_W-1:0]     dipole_z;
    logic                         cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;

    // Samples waiting to be sent and dipole commands waiting to come back.
    mag_sample_t pending_samples[$];
    dipole_cmd_t dipole_expected[$];
    dipole_cmd_t dipole_want;

    int samples_queued = 0;
    int results_seen = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    // Predictor copy of the configuration and of the filter state.
    logic [GAIN_W-1:0]          filt_gain_cfg = '0;
    logic [DECAY_W-1:0]         decay_cfg = '0;
    logic [GAIN_W-1:0]          axis_gain_cfg [AXES] = '{default: '0};
    logic signed [FIELD_W-1:0]  last_field [AXES] = '{default: '0};
    logic signed [RATE_W-1:0]   last_rate [AXES] = '{default: '0};

    // Last field queued per axis, so random sequences can wander like a real sensor.
    int walk_field [AXES] = '{default: 0};

    bdot_filtered_dipole_control dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .field_x      (field_x),
        .field_y      (field_y),
        .field_z      (field_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dipole_x     (dipole_x),
        .dipole_y     (dipole_y),
        .dipole_z     (dipole_z),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Round a Q.16 value half up, then clip it to 24-bit signed.
    function automatic logic signed [RATE_W-1:0] q16_round_clip(input longint v);
        longint s;
        s = (v + (64'sd1 <<< (Q_SHIFT - 1))) >>> Q_SHIFT;
        if (s > RATE_MAX)
        begin
            s = RATE_MAX;
        end
        else if (s < RATE_MIN)
        begin
            s = RATE_MIN;
        end
        return RATE_W'(s);
    endfunction

    // Filter one sample on all axes, command the dipole and advance the filter state.
    function automatic dipole_cmd_t filter_and_command(input mag_sample_t s);
        longint field_v;
        longint diff;
        longint acc;
        longint dip;
        logic signed [RATE_W-1:0] rate;
        dipole_cmd_t cmd;
        for (int i = 0; i < AXES; i++)
        begin
            field_v = $signed(s[i]);
            diff = field_v - longint'(last_field[i]);
            acc = longint'(filt_gain_cfg) * diff + longint'(decay_cfg) * longint'(last_rate[i]);
            rate = q16_round_clip(acc);
            dip = -(longint'(axis_gain_cfg[i]) * longint'(rate));
            cmd[i] = q16_round_clip(dip);
            last_field[i] = s[i];
            last_rate[i] = rate;
        end
        return cmd;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_count, what, got, want);
        fail_count++;
    endtask

    // Register write; the predictor takes the value masked to the register width.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_FILTER_GAIN:  filt_gain_cfg = val[GAIN_W-1:0];
            REG_DECAY_FACTOR: decay_cfg = val[DECAY_W-1:0];
            REG_GAIN_X:       axis_gain_cfg[0] = val[GAIN_W-1:0];
            REG_GAIN_Y:       axis_gain_cfg[1] = val[GAIN_W-1:0];
            REG_GAIN_Z:       axis_gain_cfg[2] = val[GAIN_W-1:0];
            default:          ;
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [GAIN_W-1:0] fg, input logic [CFG_DATA_W-1:0] dk,
                                  input logic [GAIN_W-1:0] gx, input logic [GAIN_W-1:0] gy,
                                  input logic [GAIN_W-1:0] gz);
        write_reg(REG_FILTER_GAIN, fg);
        write_reg(REG_DECAY_FACTOR, dk);
        write_reg(REG_GAIN_X, gx);
        write_reg(REG_GAIN_Y, gy);
        write_reg(REG_GAIN_Z, gz);
    endtask

    task automatic queue_fields(input int fx, input int fy, input int fz);
        mag_sample_t s;
        s[0] = FIELD_W'(fx);
        s[1] = FIELD_W'(fy);
        s[2] = FIELD_W'(fz);
        walk_field = '{fx, fy, fz};
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    // Mostly a random walk from the last sample, with jumps and rail values mixed in.
    task automatic queue_random_sample();
        int v [AXES];
        int step;
        int kind;
        for (int i = 0; i < AXES; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                step = 1 << $urandom_range(0, 12);
                v[i] = walk_field[i] + int'($urandom_range(0, 2 * step)) - step;
            end
            else if (kind < 88)
            begin
                v[i] = $signed(FIELD_W'($urandom));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       v[i] = FIELD_MIN;
                    1:       v[i] = FIELD_MAX;
                    2:       v[i] = 0;
                    default: v[i] = -1;
                endcase
            end
            if (v[i] > FIELD_MAX)
            begin
                v[i] = FIELD_MAX;
            end
            else if (v[i] < FIELD_MIN)
            begin
                v[i] = FIELD_MIN;
            end
        end
        queue_fields(v[0], v[1], v[2]);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return GAIN_W'($urandom_range(0, 24'h03FFFF));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [DECAY_W-1:0] pick_decay();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return DECAY_W'($urandom);
            default: return DECAY_W'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    // Block until every queued sample has produced its dipole command.
    task automatic wait_drained();
        wait (results_seen == samples_queued);
    endtask

    task automatic set_idling(input int snd, input int rcv);
        sender_idle_pct = snd;
        receiver_stall_pct = rcv;
    endtask

    // Sender: present the next pending sample whenever the slot is free, unless it idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                dipole_expected.push_back(filter_and_command({field_z, field_y, field_x}));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    mag_sample_t s;
                    s = pending_samples.pop_front();
                    field_x <= s[0];
                    field_y <= s[1];
                    field_z <= s[2];
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted dipole command against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (dipole_expected.size() == 0)
                begin
                    $display("[%0d] dipole item with no sample outstanding: %0d %0d %0d",
                             cycle_count, dipole_x, dipole_y, dipole_z);
                    fail_count++;
                end
                else
                begin
                    dipole_want = dipole_expected.pop_front();
                    if (dipole_x !== dipole_want[0])
                    begin
                        report_mismatch("dipole_x", dipole_x, $signed(dipole_want[0]));
                    end
                    if (dipole_y !== dipole_want[1])
                    begin
                        report_mismatch("dipole_y", dipole_y, $signed(dipole_want[1]));
                    end
                    if (dipole_z !== dipole_want[2])
                    begin
                        report_mismatch("dipole_z", dipole_z, $signed(dipole_want[2]));
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unit filter gain, half decay, distinct axis gains.
        // Decay data carries junk in its upper byte, which the register must drop.
        set_idling(0, 0);
        write_all_regs(24'h010000, 24'hAB8000, 24'h010000, 24'h020000, 24'h008000);
        for (int i = int'(REG_GAIN_Z) + 1; i < (1 << CFG_IDX_W); i++)
        begin
            write_reg(CFG_IDX_W'(i), '1);
        end
        // First sample after reset: the rate is the gain times the field itself.
        queue_fields(FIELD_MAX, FIELD_MIN, 0);
        queue_fields(FIELD_MIN, FIELD_MAX, 1);
        queue_fields(0, 0, 0);
        queue_fields(0, 0, 0);
        queue_fields(1, -1, FIELD_MAX);
        queue_fields(FIELD_MAX, FIELD_MAX, FIELD_MAX);
        queue_fields(FIELD_MIN, FIELD_MIN, FIELD_MIN);
        queue_fields(-1, 3, -3);
        wait_drained();

        // Directed: every register at its maximum, so rate and dipole both saturate.
        write_all_regs('1, '1, '1, '1, '1);
        queue_fields(FIELD_MIN, FIELD_MAX, 0);
        queue_fields(FIELD_MAX, FIELD_MIN, 0);
        queue_fields(FIELD_MAX, FIELD_MIN, 100);
        queue_fields(0, 0, FIELD_MIN);
        queue_fields(0, 0, FIELD_MIN);
        queue_fields(FIELD_MAX, 0, FIELD_MAX);
        wait_drained();

        // Directed: no new input term, the saturated rate decays at full decay.
        write_all_regs('0, '1, '1, 24'h000001, 24'h010000);
        queue_fields(5, -5, 0);
        queue_fields(FIELD_MAX, FIELD_MIN, 0);
        queue_fields(0, 0, 0);
        wait_drained();

        // Directed: all registers back to zero, every command must be zero.
        write_all_regs('0, '0, '0, '0, '0);
        queue_fields(FIELD_MAX, FIELD_MIN, 1234);
        queue_fields(FIELD_MIN, FIELD_MAX, -1234);
        wait_drained();

        // Random phases: new gains each time, idling pattern rotates.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0:       set_idling(0, 0);
                1:       set_idling(55, 0);
                2:       set_idling(0, 55);
                default: set_idling(28, 28);
            endcase
            write_all_regs(pick_gain(), {8'($urandom), pick_decay()},
                           pick_gain(), pick_gain(), pick_gain());
            write_reg(CFG_IDX_W'($urandom_range(int'(REG_GAIN_Z) + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                queue_random_sample();
                // Once, hold the sender back until every command has come back.
                if (p == 1 && n == ITEMS_PER_PHASE / 2)
                begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (dipole_expected.size() != 0)
        begin
            $display("%0d dipole items never arrived", dipole_expected.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/bfdc_pkg.sv
design/bfdc_datapath.sv
design/bfdc_controller.sv
design/bdot_filtered_dipole_control.sv
tb/tb_bdot_filtered_dipole_control.sv
